@@ src/i2cbm_pkg.sv @@
package i2cbm_pkg;

    // Request fields for one bus half-period tick or one transfer request.
    typedef struct packed {
        logic       action;
        logic       is_read;
        logic [7:0] reg_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_in_item;

    // Result fields: line levels after the tick, data handshake and status.
    typedef struct packed {
        logic       scl;
        logic       sda_drive;
        logic       data_taken;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic [2:0] status;
    } t_out_item;

    // Target address after reset.
    localparam logic [6:0] DEV_ADDR_RESET = 7'h68;

    // Status codes.
    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_BUSY        = 3'd1;
    localparam logic [2:0] ST_DONE        = 3'd2;
    localparam logic [2:0] ST_NACK_ADDR   = 3'd3;
    localparam logic [2:0] ST_NACK_REG    = 3'd4;
    localparam logic [2:0] ST_NACK_DATA   = 3'd5;
    localparam logic [2:0] ST_NACK_RDADDR = 3'd6;

endpackage

@@ src/i2cbm_in_stage.sv @@
module i2cbm_in_stage
    import i2cbm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  logic     i_take,
    output logic     o_item_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // The stage refills whenever it is empty or its request moves on.
    assign o_in_stall   = r_valid && !i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // Valid flag of the held request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload is captured only on acceptance.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_in_data;
        end
    end

endmodule

@@ src/i2cbm_core.sv @@
module i2cbm_core
    import i2cbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [6:0] i_dev_addr,
    input  logic      i_item_valid,
    input  t_in_item  i_item,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Phase codes. Transmit phases are PH_TX + kind * 4 + sub-step.
    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_FIN      = 5'd1;
    localparam logic [4:0] PH_TX       = 5'd2;
    localparam logic [4:0] PH_TX_DATA  = 5'd10;
    localparam logic [4:0] PH_TX_LAST  = 5'd17;
    localparam logic [4:0] PH_RS_LO    = 5'd18;
    localparam logic [4:0] PH_RS_HI    = 5'd19;
    localparam logic [4:0] PH_RS_START = 5'd20;
    localparam logic [4:0] PH_RX_LO    = 5'd21;
    localparam logic [4:0] PH_RX_HI    = 5'd22;
    localparam logic [4:0] PH_MA_LO    = 5'd23;
    localparam logic [4:0] PH_MA_HI    = 5'd24;
    localparam logic [4:0] PH_SP_LO    = 5'd25;
    localparam logic [4:0] PH_SP_HI    = 5'd26;
    localparam logic [4:0] PH_SP_END   = 5'd27;

    // Byte kinds within the transmit phases.
    localparam logic [1:0] K_ADDRW = 2'd0;
    localparam logic [1:0] K_REG   = 2'd1;
    localparam logic [1:0] K_DATA  = 2'd2;
    localparam logic [1:0] K_ADDRR = 2'd3;

    // Transmit sub-steps.
    localparam logic [1:0] SUB_BIT_LO = 2'd0;
    localparam logic [1:0] SUB_BIT_HI = 2'd1;
    localparam logic [1:0] SUB_ACK_LO = 2'd2;

    logic [4:0] r_phase,        n_phase;
    logic [3:0] r_bit_index,    n_bit_index;
    logic [7:0] r_shift,        n_shift;
    logic [7:0] r_bytes_left,   n_bytes_left;
    logic [7:0] r_latched_reg,  n_latched_reg;
    logic       r_read_mode,    n_read_mode;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       w_out_free;
    logic       w_step;
    logic       w_is_tx;
    logic [4:0] w_rel;
    logic [1:0] w_kind;
    logic [1:0] w_sub;
    t_out_item  w_out;

    // A request is processed when the result register can take its result.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step      = i_item_valid && w_out_free;
    assign o_take      = w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Decode of the transmit phases.
    assign w_is_tx = (r_phase >= PH_TX) && (r_phase <= PH_TX_LAST);
    assign w_rel   = r_phase - PH_TX;
    assign w_kind  = w_rel[3:2];
    assign w_sub   = w_rel[1:0];

    // Next state and line levels for one tick.
    always_comb begin
        n_phase       = r_phase;
        n_bit_index   = r_bit_index;
        n_shift       = r_shift;
        n_bytes_left  = r_bytes_left;
        n_latched_reg = r_latched_reg;
        n_read_mode   = r_read_mode;
        w_out           = '0;
        w_out.scl       = 1'b1;
        w_out.sda_drive = 1'b1;

        if (w_is_tx) begin
            if (w_sub == SUB_BIT_LO) begin
                w_out.scl       = 1'b0;
                w_out.sda_drive = r_shift[7];
                n_phase         = r_phase + 5'd1;
            end else if (w_sub == SUB_BIT_HI) begin
                w_out.sda_drive = r_shift[7];
                n_shift         = {r_shift[6:0], 1'b0};
                n_bit_index     = r_bit_index + 4'd1;
                if (n_bit_index >= 4'd8) begin
                    n_phase = r_phase + 5'd1;
                end else begin
                    n_phase = r_phase - 5'd1;
                end
            end else if (w_sub == SUB_ACK_LO) begin
                w_out.scl = 1'b0;
                n_phase   = r_phase + 5'd1;
            end else begin
                // Acknowledge sample on the high half of the acknowledge clock.
                if (i_item.sda_in) begin
                    n_phase     = PH_SP_LO;
                    n_shift     = {5'd0, {1'b0, w_kind} + ST_NACK_ADDR};
                    n_bit_index = 4'd0;
                end else if (w_kind == K_ADDRW) begin
                    n_phase     = PH_TX + {1'b0, K_REG, 2'b00};
                    n_shift     = r_latched_reg;
                    n_bit_index = 4'd0;
                end else if (w_kind == K_ADDRR) begin
                    n_phase     = PH_RX_LO;
                    n_bit_index = 4'd0;
                    n_shift     = 8'd0;
                end else if (w_kind == K_REG && r_read_mode) begin
                    n_phase = PH_RS_LO;
                end else if (w_kind == K_DATA && r_bytes_left == 8'd0) begin
                    n_phase     = PH_SP_LO;
                    n_shift     = {5'd0, ST_DONE};
                    n_bit_index = 4'd0;
                end else begin
                    n_phase          = PH_TX_DATA;
                    n_shift          = i_item.write_byte;
                    n_bit_index      = 4'd0;
                    w_out.data_taken = 1'b1;
                    if (r_bytes_left != 8'd0) begin
                        n_bytes_left = r_bytes_left - 8'd1;
                    end
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE, PH_FIN: begin
                    if (i_item.action) begin
                        n_read_mode     = i_item.is_read;
                        n_latched_reg   = i_item.reg_address;
                        n_bytes_left    = (i_item.byte_count == 8'd0) ? 8'd1
                                                                      : i_item.byte_count;
                        n_phase         = PH_TX;
                        n_shift         = {i_dev_addr, 1'b0};
                        n_bit_index     = 4'd0;
                        w_out.sda_drive = 1'b0;
                    end
                end
                PH_RS_LO: begin
                    w_out.scl = 1'b0;
                    n_phase   = PH_RS_HI;
                end
                PH_RS_HI: begin
                    n_phase = PH_RS_START;
                end
                PH_RS_START: begin
                    w_out.sda_drive = 1'b0;
                    n_phase         = PH_TX + {1'b0, K_ADDRR, 2'b00};
                    n_shift         = {i_dev_addr, 1'b1};
                    n_bit_index     = 4'd0;
                end
                PH_RX_LO: begin
                    w_out.scl = 1'b0;
                    n_phase   = PH_RX_HI;
                end
                PH_RX_HI: begin
                    n_shift     = {r_shift[6:0], i_item.sda_in};
                    n_bit_index = r_bit_index + 4'd1;
                    if (n_bit_index >= 4'd8) begin
                        w_out.read_valid = 1'b1;
                        w_out.read_byte  = n_shift;
                        w_out.read_last  = (r_bytes_left <= 8'd1);
                        if (r_bytes_left != 8'd0) begin
                            n_bytes_left = r_bytes_left - 8'd1;
                        end
                        n_phase = PH_MA_LO;
                    end else begin
                        n_phase = PH_RX_LO;
                    end
                end
                PH_MA_LO: begin
                    w_out.scl       = 1'b0;
                    w_out.sda_drive = (r_bytes_left == 8'd0);
                    n_phase         = PH_MA_HI;
                end
                PH_MA_HI: begin
                    w_out.sda_drive = (r_bytes_left == 8'd0);
                    if (r_bytes_left == 8'd0) begin
                        n_phase     = PH_SP_LO;
                        n_shift     = {5'd0, ST_DONE};
                        n_bit_index = 4'd0;
                    end else begin
                        n_phase     = PH_RX_LO;
                        n_bit_index = 4'd0;
                        n_shift     = 8'd0;
                    end
                end
                PH_SP_LO: begin
                    w_out.scl       = 1'b0;
                    w_out.sda_drive = 1'b0;
                    n_phase         = PH_SP_HI;
                end
                PH_SP_HI: begin
                    w_out.sda_drive = 1'b0;
                    n_phase         = PH_SP_END;
                end
                PH_SP_END: begin
                    n_phase = PH_FIN;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // Status follows the phase the tick leaves behind.
        if (n_phase == PH_IDLE) begin
            w_out.status = ST_IDLE;
        end else if (n_phase == PH_FIN) begin
            w_out.status = n_shift[2:0];
        end else begin
            w_out.status = ST_BUSY;
        end
    end

    // Transfer state advances once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_index   <= 4'd0;
            r_shift       <= 8'd0;
            r_bytes_left  <= 8'd0;
            r_latched_reg <= 8'd0;
            r_read_mode   <= 1'b0;
        end else if (w_step) begin
            r_phase       <= n_phase;
            r_bit_index   <= n_bit_index;
            r_shift       <= n_shift;
            r_bytes_left  <= n_bytes_left;
            r_latched_reg <= n_latched_reg;
            r_read_mode   <= n_read_mode;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= i_item_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_out;
        end
    end

`ifndef SYNTHESIS
    // The bit counter never runs past one byte.
    a_bit_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= 4'd8)
        else $error("bit counter out of range");

    // A taken data byte always starts the data transmit phase.
    a_taken_enters_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_out.data_taken) |=> (r_phase == PH_TX_DATA))
        else $error("data byte taken without entering data phase");

    // Received bytes only appear in a read transfer.
    a_read_only_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_out.read_valid) |-> r_read_mode)
        else $error("read byte reported in a write transfer");

    // A plain tick while idle keeps the block idle.
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_phase == PH_IDLE && !i_item.action) |=> (r_phase == PH_IDLE))
        else $error("idle tick left the idle phase");
`endif

endmodule

@@ src/i2c_register_burst_master.sv @@
// A request accepted into the input register passes the tick logic into the result register.
// Throughput: one request per cycle while the output is not stalled; the input register
// and the result register decouple the two channels, and the tick logic between them is one pass.
// Reset: synchronous, active low; the transfer returns to idle, the result register empties,
// and the target address register loads its default.
module i2c_register_burst_master
    import i2cbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    logic [6:0] r_dev_addr;
    logic       w_take;
    logic       w_item_valid;
    t_in_item   w_item;

    // Target address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    // Input register.
    i2cbm_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_take       (w_take),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    // Bus sequencer and result register.
    i2cbm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dev_addr   (r_dev_addr),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule
